// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cond holds in the cycle after trig.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== rtl/core/tbu_pkg.sv =====
// Shared types and constants of the triangle binormal unit.
package tbu_pkg;

   localparam int COORD_WIDTH_DEF   = 32;
   localparam int OUT_FRAC_BITS_DEF = 30;
   localparam int BIN_W             = 32;
   localparam int CORNER_W          = 2;
   localparam int NUM_CORNERS       = 3;
   localparam int NUM_AXES          = 3;
   localparam int NUM_IN_FIELDS     = 5;
   localparam int NORM_TOP          = 30;
   localparam int C_W               = NORM_TOP + 1;
   localparam int SUM_W             = 64;
   localparam int ROOT_W            = 32;
   localparam int CHUNK_W           = 16;
   localparam int RSP_FIELDS_W      = 3 * BIN_W + CORNER_W;
   localparam int RSP_TDATA_W       = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int CORNER_LSB        = 3 * BIN_W;
   localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd2;
   localparam logic [1:0]          LAST_AXIS   = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL,
      OP_DET_SAVE,
      OP_VEC_SAVE,
      OP_NORM,
      OP_SQ,
      OP_SUM,
      OP_SQRT,
      OP_DIV,
      OP_EMIT
   } dp_op_type;

   // Edge and texcoord differences as seen from the current corner.
   typedef enum logic [2:0] {
      OPD_D1,
      OPD_D2,
      OPD_S1,
      OPD_S2,
      OPD_T1,
      OPD_T2
   } opd_type;

   typedef struct packed {
      dp_op_type           op;
      opd_type             sel_a;
      opd_type             sel_b;
      logic                sub;
      logic                clr;
      logic [CORNER_W-1:0] corner;
      logic [1:0]          axis;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic det_zero;
      logic vec_zero;
      logic norm_done;
      logic out_full;
   } dp_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DET_A,
      ST_DET_AW,
      ST_DET_B,
      ST_DET_BW,
      ST_DET_SAVE,
      ST_CORNER,
      ST_VEC_A,
      ST_VEC_AW,
      ST_VEC_B,
      ST_VEC_BW,
      ST_VEC_SAVE,
      ST_VEC_CHK,
      ST_NORM,
      ST_SQ,
      ST_SUM,
      ST_SQRT,
      ST_SQRT_W,
      ST_DIV,
      ST_DIV_W,
      ST_EMIT
   } ctl_state_type;

endpackage

// ===== rtl/core/tbu_datapath.sv =====
// Datapath: corner store, serial multiplier, normalizer, square root and divider.
module tbu_datapath import tbu_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   output dp_stat_type                   stat,
   input  logic signed [COORD_WIDTH-1:0] in_pos_x,
   input  logic signed [COORD_WIDTH-1:0] in_pos_y,
   input  logic signed [COORD_WIDTH-1:0] in_pos_z,
   input  logic signed [COORD_WIDTH-1:0] in_tex_u,
   input  logic signed [COORD_WIDTH-1:0] in_tex_v,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [BIN_W-1:0]       out_bin_x,
   output logic signed [BIN_W-1:0]       out_bin_y,
   output logic signed [BIN_W-1:0]       out_bin_z,
   output logic [CORNER_W-1:0]           out_corner,
   output logic                          out_degenerate,
   output logic                          out_last
);

   localparam int DW     = COORD_WIDTH + 1;
   localparam int NCH    = (DW + CHUNK_W - 1) / CHUNK_W;
   localparam int BW     = NCH * CHUNK_W;
   localparam int PW     = DW + BW;
   localparam int PROD_W = 2 * DW;
   localparam int VW     = 2 * DW + 2;
   localparam int QB     = OUT_FRAC_BITS + 1;
   localparam int NW     = C_W + OUT_FRAC_BITS + 1;
   localparam int MCNT_W = $clog2(NCH + 1);
   localparam int SCNT_W = $clog2(ROOT_W + 1);
   localparam int DCNT_W = $clog2(QB + 1);

   function automatic logic signed [DW-1:0] dif(input logic signed [COORD_WIDTH-1:0] x,
                                                input logic signed [COORD_WIDTH-1:0] y);
      return {x[COORD_WIDTH-1], x} - {y[COORD_WIDTH-1], y};
   endfunction

   function automatic logic [DW-1:0] absd(input logic signed [DW-1:0] x);
      return x[DW-1] ? DW'(-x) : DW'(x);
   endfunction

   // corner store
   logic signed [COORD_WIDTH-1:0] pos_ff [NUM_CORNERS][NUM_AXES];
   logic signed [COORD_WIDTH-1:0] tu_ff  [NUM_CORNERS];
   logic signed [COORD_WIDTH-1:0] tv_ff  [NUM_CORNERS];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         pos_ff[cmd.corner][0] <= in_pos_x;
         pos_ff[cmd.corner][1] <= in_pos_y;
         pos_ff[cmd.corner][2] <= in_pos_z;
         tu_ff[cmd.corner]     <= in_tex_u;
         tv_ff[cmd.corner]     <= in_tex_v;
      end
   end

   // operand select
   logic [CORNER_W-1:0]   ca, cb;
   logic signed [DW-1:0]  d1, d2, s1, s2, t1, t2, opa, opb;

   function automatic logic signed [DW-1:0] pick(input opd_type s,
      input logic signed [DW-1:0] x1, input logic signed [DW-1:0] x2,
      input logic signed [DW-1:0] u1, input logic signed [DW-1:0] u2,
      input logic signed [DW-1:0] v1, input logic signed [DW-1:0] v2);
      logic signed [DW-1:0] r;
      case (s)
         OPD_D1:  r = x1;
         OPD_D2:  r = x2;
         OPD_S1:  r = u1;
         OPD_S2:  r = u2;
         OPD_T1:  r = v1;
         OPD_T2:  r = v2;
         default: r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      unique case (cmd.corner)
         2'd0:    begin ca = 2'd1; cb = 2'd2; end
         2'd1:    begin ca = 2'd2; cb = 2'd0; end
         default: begin ca = 2'd0; cb = 2'd1; end
      endcase
      d1  = dif(pos_ff[ca][cmd.axis], pos_ff[cmd.corner][cmd.axis]);
      d2  = dif(pos_ff[cb][cmd.axis], pos_ff[cmd.corner][cmd.axis]);
      s1  = dif(tu_ff[ca], tu_ff[cmd.corner]);
      s2  = dif(tu_ff[cb], tu_ff[cmd.corner]);
      t1  = dif(tv_ff[ca], tv_ff[cmd.corner]);
      t2  = dif(tv_ff[cb], tv_ff[cmd.corner]);
      opa = pick(cmd.sel_a, d1, d2, s1, s2, t1, t2);
      opb = pick(cmd.sel_b, d1, d2, s1, s2, t1, t2);
   end

   // serial multiplier, one 16-bit chunk of the second operand per cycle
   logic [MCNT_W-1:0]      mcnt_ff, mcnt_in;
   logic                   mfin_ff, mfin_in;
   logic [DW-1:0]          ma_ff;
   logic [BW-1:0]          mb_ff;
   logic                   mneg_ff;
   logic [PW-1:0]          pacc_ff, pacc_in;
   logic [DW+CHUNK_W-1:0]  partial;
   logic signed [VW-1:0]   acc_ff;
   logic [VW-1:0]          pmag;

   always_comb begin
      mcnt_in = mcnt_ff;
      mfin_in = 1'b0;
      if (cmd.op == OP_MUL) begin
         mcnt_in = MCNT_W'(NCH);
      end else if (mcnt_ff != '0) begin
         mcnt_in = mcnt_ff - 1'b1;
         mfin_in = (mcnt_ff == MCNT_W'(1));
      end
      partial = ma_ff * mb_ff[BW-1 -: CHUNK_W];
      pacc_in = (pacc_ff << CHUNK_W) + PW'(partial);
      pmag    = VW'(pacc_ff[PROD_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff <= '0;
         mfin_ff <= 1'b0;
      end else begin
         mcnt_ff <= mcnt_in;
         mfin_ff <= mfin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MUL) begin
         ma_ff   <= absd(opa);
         mb_ff   <= BW'(absd(opb));
         mneg_ff <= opa[DW-1] ^ opb[DW-1] ^ cmd.sub;
         pacc_ff <= '0;
      end else if (mcnt_ff != '0) begin
         pacc_ff <= pacc_in;
         mb_ff   <= mb_ff << CHUNK_W;
      end
      if (cmd.op == OP_MUL && cmd.clr) begin
         acc_ff <= '0;
      end else if (mfin_ff) begin
         acc_ff <= mneg_ff ? acc_ff - pmag : acc_ff + pmag;
      end
   end

   // determinant and vector magnitudes
   logic            det_neg_ff, det_zero_ff;
   logic [VW-1:0]   mag_ff [NUM_AXES];
   logic            neg_ff [NUM_AXES];
   logic [VW-1:0]   anyv;
   logic            hi_bits;

   always_comb begin
      anyv    = mag_ff[0] | mag_ff[1] | mag_ff[2];
      hi_bits = |anyv[VW-1:NORM_TOP+1];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DET_SAVE) begin
         det_neg_ff  <= acc_ff[VW-1];
         det_zero_ff <= (acc_ff == '0);
      end
      if (cmd.op == OP_VEC_SAVE) begin
         mag_ff[cmd.axis] <= acc_ff[VW-1] ? VW'(-acc_ff) : VW'(acc_ff);
         neg_ff[cmd.axis] <= acc_ff[VW-1] ^ det_neg_ff;
      end else if (cmd.op == OP_NORM) begin
         for (int k = 0; k < NUM_AXES; k++) begin
            mag_ff[k] <= hi_bits ? (mag_ff[k] >> 1) : (mag_ff[k] << 1);
         end
      end
   end

   // sum of squares
   logic [C_W-1:0]   cval;
   logic [2*C_W-1:0] sq_ff;
   logic [SUM_W-1:0] sum_ff;

   assign cval = mag_ff[cmd.axis][C_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SQ) begin
         sq_ff  <= cval * cval;
         sum_ff <= (cmd.axis == '0) ? '0 : sum_ff + SUM_W'(sq_ff);
      end else if (cmd.op == OP_SUM) begin
         sum_ff <= sum_ff + SUM_W'(sq_ff);
      end
   end

   // square root, one result bit per cycle
   logic [SCNT_W-1:0]   scnt_ff, scnt_in;
   logic [SUM_W-1:0]    sqs_ff;
   logic [ROOT_W+1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   rt_ff, rt_in;
   logic [ROOT_W+3:0]   rem2, strial, sdiff;
   logic                sge;

   always_comb begin
      scnt_in = scnt_ff;
      if (cmd.op == OP_SQRT) begin
         scnt_in = SCNT_W'(ROOT_W);
      end else if (scnt_ff != '0) begin
         scnt_in = scnt_ff - 1'b1;
      end
      rem2    = {srem_ff, sqs_ff[SUM_W-1 -: 2]};
      strial  = {2'b00, rt_ff, 2'b01};
      sge     = (rem2 >= strial);
      sdiff   = rem2 - strial;
      srem_in = sge ? sdiff[ROOT_W+1:0] : rem2[ROOT_W+1:0];
      rt_in   = {rt_ff[ROOT_W-2:0], sge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scnt_ff <= '0;
      end else begin
         scnt_ff <= scnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_SQRT) begin
         sqs_ff  <= sum_ff;
         srem_ff <= '0;
         rt_ff   <= '0;
      end else if (scnt_ff != '0) begin
         sqs_ff  <= sqs_ff << 2;
         srem_ff <= srem_in;
         rt_ff   <= rt_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic [ROOT_W-1:0]     drem_ff, drem_in;
   logic [QB-1:0]         dnum_ff, dq_ff, dq_in, qsat;
   logic [1:0]            dax_ff;
   logic                  dneg_ff;
   logic [NW-1:0]         nval;
   logic [ROOT_W:0]       dt, ddiff;
   logic                  dge;
   logic [BIN_W-1:0]      qmag;
   logic signed [BIN_W-1:0] qout_ff [NUM_AXES];
   localparam logic [QB-1:0] QLIM = QB'(1) << OUT_FRAC_BITS;

   always_comb begin
      dcnt_in = dcnt_ff;
      if (cmd.op == OP_DIV) begin
         dcnt_in = DCNT_W'(QB);
      end else if (dcnt_ff != '0) begin
         dcnt_in = dcnt_ff - 1'b1;
      end
      nval    = (NW'(cval) << OUT_FRAC_BITS) + NW'(rt_ff >> 1);
      dt      = {drem_ff, dnum_ff[QB-1]};
      ddiff   = dt - {1'b0, rt_ff};
      dge     = (dt >= {1'b0, rt_ff});
      drem_in = dge ? ddiff[ROOT_W-1:0] : dt[ROOT_W-1:0];
      dq_in   = {dq_ff[QB-2:0], dge};
      qsat    = (dq_in > QLIM) ? QLIM : dq_in;
      qmag    = BIN_W'(qsat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else begin
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DIV) begin
         drem_ff <= ROOT_W'(nval[NW-1:QB]);
         dnum_ff <= nval[QB-1:0];
         dq_ff   <= '0;
         dax_ff  <= cmd.axis;
         dneg_ff <= neg_ff[cmd.axis];
      end else if (dcnt_ff != '0) begin
         drem_ff <= drem_in;
         dnum_ff <= dnum_ff << 1;
         dq_ff   <= dq_in;
         if (dcnt_ff == DCNT_W'(1)) begin
            qout_ff[dax_ff] <= dneg_ff ? -qmag : qmag;
         end
      end
   end

   // result register
   logic out_valid_ff;
   logic degen;

   assign degen = det_zero_ff | (anyv == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         out_bin_x      <= degen ? '0 : qout_ff[0];
         out_bin_y      <= degen ? '0 : qout_ff[1];
         out_bin_z      <= degen ? '0 : qout_ff[2];
         out_corner     <= cmd.corner;
         out_degenerate <= degen;
         out_last       <= (cmd.corner == LAST_CORNER);
      end
   end

   assign out_valid = out_valid_ff;

   always_comb begin
      stat.busy      = (mcnt_ff != '0) | mfin_ff | (scnt_ff != '0) | (dcnt_ff != '0);
      stat.det_zero  = det_zero_ff;
      stat.vec_zero  = (anyv == '0);
      stat.norm_done = !hi_bits && anyv[NORM_TOP];
      stat.out_full  = out_valid_ff;
   end

endmodule

// ===== rtl/core/tbu_control.sv =====
// Controller: sequences corner capture and the per-corner binormal steps.
module tbu_control import tbu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   ctl_state_type       state_ff, state_in;
   logic [1:0]          count_ff, count_in;
   logic [CORNER_W-1:0] jdx_ff, jdx_in;
   logic [1:0]          axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         jdx_ff   <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         jdx_ff   <= jdx_in;
         axis_ff  <= axis_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      jdx_in     = jdx_ff;
      axis_in    = axis_ff;
      req_ready  = 1'b0;
      cmd.op     = OP_NONE;
      cmd.sel_a  = OPD_D1;
      cmd.sel_b  = OPD_D1;
      cmd.sub    = 1'b0;
      cmd.clr    = 1'b0;
      cmd.corner = jdx_ff;
      cmd.axis   = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LOAD;
               if (count_ff[1]) begin
                  cmd.corner = LAST_CORNER;
                  count_in   = '0;
                  jdx_in     = '0;
                  state_in   = ST_DET_A;
               end else begin
                  cmd.corner = count_ff;
                  count_in   = count_ff + 1'b1;
               end
            end
         end
         ST_DET_A: begin
            cmd.op    = OP_MUL;
            cmd.sel_a = OPD_S1;
            cmd.sel_b = OPD_T2;
            cmd.clr   = 1'b1;
            state_in  = ST_DET_AW;
         end
         ST_DET_AW: if (!stat.busy) state_in = ST_DET_B;
         ST_DET_B: begin
            cmd.op    = OP_MUL;
            cmd.sel_a = OPD_S2;
            cmd.sel_b = OPD_T1;
            cmd.sub   = 1'b1;
            state_in  = ST_DET_BW;
         end
         ST_DET_BW: if (!stat.busy) state_in = ST_DET_SAVE;
         ST_DET_SAVE: begin
            cmd.op   = OP_DET_SAVE;
            state_in = ST_CORNER;
         end
         ST_CORNER: begin
            axis_in  = '0;
            state_in = stat.det_zero ? ST_EMIT : ST_VEC_A;
         end
         ST_VEC_A: begin
            cmd.op    = OP_MUL;
            cmd.sel_a = OPD_D2;
            cmd.sel_b = OPD_S1;
            cmd.clr   = 1'b1;
            state_in  = ST_VEC_AW;
         end
         ST_VEC_AW: if (!stat.busy) state_in = ST_VEC_B;
         ST_VEC_B: begin
            cmd.op    = OP_MUL;
            cmd.sel_a = OPD_D1;
            cmd.sel_b = OPD_S2;
            cmd.sub   = 1'b1;
            state_in  = ST_VEC_BW;
         end
         ST_VEC_BW: if (!stat.busy) state_in = ST_VEC_SAVE;
         ST_VEC_SAVE: begin
            cmd.op = OP_VEC_SAVE;
            if (axis_ff == LAST_AXIS) begin
               axis_in  = '0;
               state_in = ST_VEC_CHK;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_VEC_A;
            end
         end
         ST_VEC_CHK: state_in = stat.vec_zero ? ST_EMIT : ST_NORM;
         ST_NORM: begin
            if (stat.norm_done) begin
               axis_in  = '0;
               state_in = ST_SQ;
            end else begin
               cmd.op = OP_NORM;
            end
         end
         ST_SQ: begin
            cmd.op = OP_SQ;
            if (axis_ff == LAST_AXIS) begin
               state_in = ST_SUM;
            end else begin
               axis_in = axis_ff + 1'b1;
            end
         end
         ST_SUM: begin
            cmd.op   = OP_SUM;
            axis_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.op   = OP_SQRT;
            state_in = ST_SQRT_W;
         end
         ST_SQRT_W: if (!stat.busy) state_in = ST_DIV;
         ST_DIV: begin
            cmd.op   = OP_DIV;
            state_in = ST_DIV_W;
         end
         ST_DIV_W: begin
            if (!stat.busy) begin
               if (axis_ff == LAST_AXIS) begin
                  state_in = ST_EMIT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_DIV;
               end
            end
         end
         ST_EMIT: begin
            if (!stat.out_full) begin
               cmd.op = OP_EMIT;
               if (jdx_ff == LAST_CORNER) begin
                  state_in = ST_IDLE;
               end else begin
                  jdx_in   = jdx_ff + 1'b1;
                  state_in = ST_CORNER;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/triangle_binormal_unit_core.sv =====
// Triangle binormal unit: takes three textured corners and returns one unit
// binormal per corner. Corners arrive as req items; the first two are stored
// and taken one per cycle. The third starts the computation: one determinant,
// then per corner six serial multiplications (one 16-bit chunk a cycle, three
// chunks for the default 33-bit differences), a normalizing shift of one bit
// per cycle, three squares, a 32-step square root and three 31-step divisions
// for the default 30 fraction bits; the serial divider and square root
// dominate. A zero determinant sends a corner straight to its result, and a
// zero vector skips its normalizing, squares, root and divisions. Results leave
// through an output register, so the first corner of the next triangle is
// taken while the last result still waits on rsp_tready. A zero determinant
// or a zero vector gives a zero binormal with the degenerate flag set in
// rsp_tuser.
module triangle_binormal_unit_core import tbu_pkg::*; #(
   parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v (COORD_WIDTH bits each), zero pad
   input  logic [((NUM_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // bin_x, bin_y, bin_z (32 bits each), corner (2 bits), zero pad
   output logic [RSP_TDATA_W-1:0]                       rsp_tdata,
   // degenerate
   output logic                                         rsp_tuser,
   output logic                                         rsp_tlast
);

   localparam int CW = COORD_WIDTH;

   dp_cmd_type              cmd;
   dp_stat_type             stat;
   logic signed [BIN_W-1:0] bin_x, bin_y, bin_z;
   logic [CORNER_W-1:0]     corner;

   // Sequence the work; take items only while idle.
   tbu_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Unpack the corner fields straight into the datapath store.
   tbu_datapath #(
      .COORD_WIDTH   (COORD_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_pos_x       (req_tdata[CW-1:0]),
      .in_pos_y       (req_tdata[2*CW-1:CW]),
      .in_pos_z       (req_tdata[3*CW-1:2*CW]),
      .in_tex_u       (req_tdata[4*CW-1:3*CW]),
      .in_tex_v       (req_tdata[5*CW-1:4*CW]),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_bin_x      (bin_x),
      .out_bin_y      (bin_y),
      .out_bin_z      (bin_z),
      .out_corner     (corner),
      .out_degenerate (rsp_tuser),
      .out_last       (rsp_tlast)
   );

   // Pack the result, lowest field first.
   assign rsp_tdata = RSP_TDATA_W'({corner, bin_z, bin_y, bin_x});

endmodule

// ===== rtl/core/tbu_checker.sv =====
// Port-level checker for the triangle binormal unit and its bind.
`include "assert_macros.svh"

module tbu_checker import tbu_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tuser,
   input logic                   rsp_tlast
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result dropped or changed while stalled")
   `ASSERT_CLK(a_degen_zero, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[CORNER_LSB-1:0] == '0), "degenerate result with nonzero binormal")
   `ASSERT_CLK(a_last_corner, clock, reset, rsp_tvalid |-> (rsp_tlast == (rsp_tdata[CORNER_LSB+1:CORNER_LSB] == LAST_CORNER)), "tlast not on the last corner")
   `ASSERT_CLK(a_corner_range, clock, reset, rsp_tvalid |-> (rsp_tdata[CORNER_LSB+1:CORNER_LSB] != 2'd3), "corner index out of range")

endmodule

bind triangle_binormal_unit_core tbu_checker u_tbu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
